[hw/rtl/vps_pkg.sv]
package vps_pkg;

	localparam int COEF_W = 20;
	localparam int Q_W    = 32;
	localparam int SIZE_W = 12;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 60;

	// quotient bits resolved by the divider chain; larger quotients saturate anyway
	localparam int QB     = 34;
	localparam int REM_W  = 33;
	localparam int PROD_W = Q_W + SIZE_W;

	localparam logic [IDX_W-1:0] REG_M0     = 3'd0;
	localparam logic [IDX_W-1:0] REG_M1     = 3'd1;
	localparam logic [IDX_W-1:0] REG_M2     = 3'd2;
	localparam logic [IDX_W-1:0] REG_M3     = 3'd3;
	localparam logic [IDX_W-1:0] REG_M4     = 3'd4;
	localparam logic [IDX_W-1:0] REG_M5     = 3'd5;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd6;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd7;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0]    bits;
		logic [QB-1:0]    quo;
		logic [REM_W-1:0] den;
	} div_t;

	function automatic logic [Q_W-1:0] sat_q(input logic signed [39:0] x);
		logic [Q_W-1:0] r;
		if (x > 40'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -40'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/vps_div_cell.sv]
module vps_div_cell (
	input  logic          clk,
	input  logic          en,
	input  vps_pkg::div_t din,
	output vps_pkg::div_t dout
);

	logic [vps_pkg::REM_W:0] t;
	logic [vps_pkg::REM_W:0] diff;
	logic                    ge;

	always_comb begin
		t    = {din.rem, din.bits[vps_pkg::QB-1]};
		ge   = t >= {1'b0, din.den};
		diff = t - {1'b0, din.den};
	end

	// remainder stays below the divisor, so the top bit drops
	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem  <= ge ? diff[vps_pkg::REM_W-1:0] : t[vps_pkg::REM_W-1:0];
			dout.bits <= {din.bits[vps_pkg::QB-2:0], 1'b0};
			dout.quo  <= {din.quo[vps_pkg::QB-2:0], ge};
			dout.den  <= din.den;
		end
	end

endmodule

[hw/rtl/vertex_projection_to_screen_unit.sv]
// Throughput: one vertex per cycle while no held result is stalled; the screen divide is
// a chain of 34 one-bit divider cells per axis, each cell resolving one quotient bit per cycle.
// A vertex with clip w of zero or less produces no result.
// Reset clears the pipeline valid bits, the matrix to zero and the screen to 640x480.
module vertex_projection_to_screen_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vps_pkg::IDX_W-1:0]           cfg_index,
	input  logic [vps_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [31:0]                  vertex_x,
	input  logic signed [31:0]                  vertex_y,
	input  logic signed [31:0]                  vertex_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  pixel_x,
	output logic signed [31:0]                  pixel_y,
	output logic signed [31:0]                  clip_depth,
	output logic [30:0]                         clip_weight
);

	localparam int QB = vps_pkg::QB;

	logic signed [vps_pkg::COEF_W-1:0] coef_q [16];
	logic [vps_pkg::SIZE_W-1:0]        width_q;
	logic [vps_pkg::SIZE_W-1:0]        height_q;

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) coef_q[i] <= '0;
			width_q  <= 12'd640;
			height_q <= 12'd480;
		end else if (cfg_we) begin
			for (int r = 0; r < 5; r++) begin
				for (int k = 0; k < 3; k++) begin
					if (cfg_index == vps_pkg::IDX_W'(vps_pkg::REG_M0 + r))
						coef_q[3*r+k] <= cfg_data[20*k +: 20];
				end
			end
			if (cfg_index == vps_pkg::REG_M5) coef_q[15] <= cfg_data[19:0];
			if (cfg_index == vps_pkg::REG_WIDTH) width_q <= cfg_data[11:0];
			if (cfg_index == vps_pkg::REG_HEIGHT) height_q <= cfg_data[11:0];
		end
	end

	// whole pipeline advances unless a held result is being stalled
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: products
	logic               v_s1;
	logic signed [51:0] prod_s1 [4][3];

	// stage 2: row sums, 30 fraction bits
	logic               v_s2;
	logic signed [53:0] acc_s2 [4];

	// stage 3: round and saturate to Q16.16
	logic               v_s3;
	logic [31:0]        clip_s3 [4];

	// stage 4: scale by screen size
	logic                     v_s4;
	logic signed [vps_pkg::PROD_W-1:0] px_s4, py_s4;
	logic [31:0]              z_s4, w_s4;

	// stage 5: divider setup
	logic        v_s5;
	logic        negx_s5, negy_s5, ovfx_s5, ovfy_s5;
	logic [31:0] z_s5, w_s5;
	vps_pkg::div_t dx_s5, dy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && ($signed(clip_s3[3]) > 32'sd0);
			v_s5 <= v_s4;
		end
	end

	logic [vps_pkg::PROD_W-1:0] absx, absy;
	logic [vps_pkg::REM_W-1:0]  remx0, remy0, den0;

	always_comb begin
		absx  = px_s4[vps_pkg::PROD_W-1] ? vps_pkg::PROD_W'(-px_s4) : px_s4;
		absy  = py_s4[vps_pkg::PROD_W-1] ? vps_pkg::PROD_W'(-py_s4) : py_s4;
		remx0 = vps_pkg::REM_W'(absx[vps_pkg::PROD_W-1:18]);
		remy0 = vps_pkg::REM_W'(absy[vps_pkg::PROD_W-1:18]);
		den0  = {w_s4, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= coef_q[4*r]   * vertex_x;
				prod_s1[r][1] <= coef_q[4*r+1] * vertex_y;
				prod_s1[r][2] <= coef_q[4*r+2] * vertex_z;
			end
			for (int r = 0; r < 4; r++) begin
				acc_s2[r] <= 54'(prod_s1[r][0]) + 54'(prod_s1[r][1]) + 54'(prod_s1[r][2])
					+ (54'(coef_q[4*r+3]) <<< 16);
			end
			for (int r = 0; r < 4; r++) begin
				clip_s3[r] <= vps_pkg::sat_q(40'((acc_s2[r] + 54'sd8192) >>> 14));
			end
			px_s4 <= $signed(clip_s3[0]) * $signed({1'b0, width_q});
			py_s4 <= $signed(clip_s3[1]) * $signed({1'b0, height_q});
			z_s4  <= clip_s3[2];
			w_s4  <= clip_s3[3];
			negx_s5 <= px_s4[vps_pkg::PROD_W-1];
			negy_s5 <= py_s4[vps_pkg::PROD_W-1];
			ovfx_s5 <= remx0 >= den0;
			ovfy_s5 <= remy0 >= den0;
			z_s5    <= z_s4;
			w_s5    <= w_s4;
			dx_s5   <= '{rem: remx0, bits: {absx[17:0], 16'b0}, quo: '0, den: den0};
			dy_s5   <= '{rem: remy0, bits: {absy[17:0], 16'b0}, quo: '0, den: den0};
		end
	end

	// divider chains plus matching delay line for the side data
	vps_pkg::div_t dx [QB+1];
	vps_pkg::div_t dy [QB+1];
	logic          v_d    [QB+1];
	logic          negx_d [QB+1];
	logic          negy_d [QB+1];
	logic          ovfx_d [QB+1];
	logic          ovfy_d [QB+1];
	logic [31:0]   z_d    [QB+1];
	logic [31:0]   w_d    [QB+1];

	assign dx[0]     = dx_s5;
	assign dy[0]     = dy_s5;
	assign v_d[0]    = v_s5;
	assign negx_d[0] = negx_s5;
	assign negy_d[0] = negy_s5;
	assign ovfx_d[0] = ovfx_s5;
	assign ovfy_d[0] = ovfy_s5;
	assign z_d[0]    = z_s5;
	assign w_d[0]    = w_s5;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		vps_div_cell u_cx (.clk(clk), .en(en), .din(dx[k]), .dout(dx[k+1]));
		vps_div_cell u_cy (.clk(clk), .en(en), .din(dy[k]), .dout(dy[k+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (en) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				negx_d[k+1] <= negx_d[k];
				negy_d[k+1] <= negy_d[k];
				ovfx_d[k+1] <= ovfx_d[k];
				ovfy_d[k+1] <= ovfy_d[k];
				z_d[k+1]    <= z_d[k];
				w_d[k+1]    <= w_d[k];
			end
		end
	end

	logic [QB-1:0]      qx, qy;
	logic signed [35:0] sx, sy;
	logic signed [39:0] fx, fy;

	always_comb begin
		qx = ovfx_d[QB] ? '1 : dx[QB].quo;
		qy = ovfy_d[QB] ? '1 : dy[QB].quo;
		sx = negx_d[QB] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
		sy = negy_d[QB] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
		fx = 40'(sx) + $signed({13'b0, width_q, 15'b0});
		fy = 40'(sy) + $signed({13'b0, height_q, 15'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_x     <= vps_pkg::sat_q(fx);
			pixel_y     <= vps_pkg::sat_q(fy);
			clip_depth  <= z_d[QB];
			clip_weight <= w_d[QB][30:0];
		end
	end

	a_w_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (clip_weight != 31'd0))
		else $error("result with nonpositive clip w");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a held result");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_d[QB] && !ovfx_d[QB]) |-> (dx[QB].rem < dx[QB].den))
		else $error("divider remainder out of range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(pixel_x) && $stable(clip_weight))
		else $error("held result changed");

endmodule

[bench/vertex_projection_to_screen_unit_test.sv]
module vertex_projection_to_screen_unit_test;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] depth;
		logic [30:0]        weight;
	} screen_pt_t;

	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [vps_pkg::IDX_W-1:0]    cfg_index;
	logic [vps_pkg::CFG_W-1:0]    cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic signed [31:0]           vertex_x;
	logic signed [31:0]           vertex_y;
	logic signed [31:0]           vertex_z;
	logic                         out_valid;
	logic                         out_stall;
	logic signed [31:0]           pixel_x;
	logic signed [31:0]           pixel_y;
	logic signed [31:0]           clip_depth;
	logic [30:0]                  clip_weight;

	vertex_projection_to_screen_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.clip_depth(clip_depth), .clip_weight(clip_weight)
	);

	// predictor state
	longint coef [16];
	longint scr_w, scr_h;

	vertex_t    vertex_q [$];
	screen_pt_t projected_q [$];
	int send_idle_pct, recv_idle_pct;
	bit hold_send;
	int mismatches;
	int idle_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint sext20(logic [19:0] f);
		return longint'($signed(f));
	endfunction

	function automatic longint round_to_q16(longint acc);
		longint t;
		t = acc + 8192;
		return t >>> 14;
	endfunction

	function automatic longint map_axis(longint c, longint sz, longint w);
		longint num, mag, q;
		num = c * sz * 65536;
		mag = (num < 0 ? -num : num) / (2 * w);
		q = num < 0 ? -mag : mag;
		return sat32(q + sz * 32768);
	endfunction

	// returns 1 and fills pt when the vertex is in front of the camera
	function automatic bit project_vertex(vertex_t v, output screen_pt_t pt);
		longint vc [4];
		longint clip [4];
		longint acc;
		vc[0] = v.x; vc[1] = v.y; vc[2] = v.z; vc[3] = 65536;
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int c = 0; c < 4; c++) acc += coef[r*4+c] * vc[c];
			clip[r] = sat32(round_to_q16(acc));
		end
		pt = '0;
		if (clip[3] <= 0) return 1'b0;
		pt.sx = 32'(map_axis(clip[0], scr_w, clip[3]));
		pt.sy = 32'(map_axis(clip[1], scr_h, clip[3]));
		pt.depth = 32'(clip[2]);
		pt.weight = 31'(clip[3]);
		return 1'b1;
	endfunction

	task automatic write_reg(logic [vps_pkg::IDX_W-1:0] idx, logic [vps_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < vps_pkg::REG_M5) begin
			for (int k = 0; k < 3; k++) coef[idx*3+k] = sext20(val[k*20 +: 20]);
		end else if (idx == vps_pkg::REG_M5) begin
			coef[15] = sext20(val[19:0]);
		end else if (idx == vps_pkg::REG_WIDTH) begin
			scr_w = val[11:0];
		end else begin
			scr_h = val[11:0];
		end
	endtask

	task automatic wait_idle();
		while (vertex_q.size() != 0 || in_valid || projected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [19:0] coef_field(int mode);
		case (mode)
			0: return 20'h7ffff;
			1: return 20'h80000;
			2: return 20'h04000;
			default: return 20'($urandom);
		endcase
	endfunction

	// matrix with an optional w row of nonnegative weights and a positive offset
	task automatic load_matrix(int mode, bit sane);
		logic [vps_pkg::CFG_W-1:0] w;
		for (int i = 0; i < 5; i++) begin
			w = {coef_field(mode), coef_field(mode), coef_field(mode)};
			if (sane && i >= 4) w = {20'($urandom_range(0, 400)), 20'($urandom_range(0, 400)),
				20'($urandom_range(0, 400))};
			write_reg(vps_pkg::IDX_W'(vps_pkg::REG_M0 + i), w);
		end
		write_reg(vps_pkg::REG_M5, sane ? 60'($urandom_range(16384, 200000))
			: {40'($urandom), coef_field(mode)});
	endtask

	function automatic logic [31:0] rand_coord(int kind);
		case (kind)
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_random(int n);
		vertex_t v;
		for (int i = 0; i < n; i++) begin
			v.x = rand_coord($urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 3));
			v.y = rand_coord($urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 3));
			v.z = $urandom_range(0, 9) < 7 ? 32'($urandom_range(0, 1000000))
				: rand_coord($urandom_range(0, 3));
			vertex_q.push_back(v);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			vertex_x <= '0; vertex_y <= '0; vertex_z <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				screen_pt_t pt;
				if (project_vertex(vertex_t'{vertex_x, vertex_y, vertex_z}, pt))
					projected_q.push_back(pt);
			end
			if (!in_valid || !in_stall) begin
				if (vertex_q.size() != 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
					vertex_t v;
					v = vertex_q.pop_front();
					in_valid <= 1'b1;
					vertex_x <= v.x; vertex_y <= v.y; vertex_z <= v.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			mismatches <= 0;
			idle_cycles <= 0;
		end else begin
			out_stall <= $urandom_range(0, 99) < recv_idle_pct;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (projected_q.size() == 0) begin
					if (mismatches < 10) $display("unexpected result sx=%0d sy=%0d", pixel_x, pixel_y);
					mismatches <= mismatches + 1;
				end else begin
					screen_pt_t e;
					e = projected_q.pop_front();
					if (e.sx !== pixel_x || e.sy !== pixel_y || e.depth !== clip_depth ||
						e.weight !== clip_weight) begin
						if (mismatches < 10)
							$display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
								e.sx, e.sy, e.depth, e.weight,
								pixel_x, pixel_y, clip_depth, clip_weight);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		hold_send = 1'b0;
		send_idle_pct = 7; recv_idle_pct = 69;
		for (int i = 0; i < 16; i++) coef[i] = 0;
		scr_w = 640; scr_h = 480;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// zero matrix: w is zero, nothing comes out
		vertex_q.push_back('{32'h7fffffff, 32'h80000000, 32'h0});
		wait_idle();

		// sparse matrix: x row copies x, y row copies x plus one, z row is zero, w row copies y plus one
		write_reg(vps_pkg::REG_M0, {20'h0, 20'h0, 20'h04000});
		write_reg(vps_pkg::REG_M1, {20'h0, 20'h04000, 20'h0});
		write_reg(vps_pkg::REG_M2, {20'h0, 20'h04000, 20'h0});
		write_reg(vps_pkg::REG_M3, {20'h0, 20'h0, 20'h0});
		write_reg(vps_pkg::REG_M4, {20'h0, 20'h04000, 20'h0});
		write_reg(vps_pkg::REG_M5, 60'h04000);
		vertex_q.push_back('{32'h00010000, 32'h00020000, 32'h00030000});
		vertex_q.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
		vertex_q.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
		vertex_q.push_back('{32'h0, 32'h0, 32'hffff0000});
		vertex_q.push_back('{32'h0, 32'h0, 32'hfffe0000});
		vertex_q.push_back('{32'h12345678, 32'hedcba987, 32'h00000001});
		vertex_q.push_back('{32'hffffffff, 32'h00000001, 32'h0});
		push_random(10);
		wait_idle();

		// screen size extremes
		write_reg(vps_pkg::REG_WIDTH, 60'hfff);
		write_reg(vps_pkg::REG_HEIGHT, 60'h0);
		push_random(40);
		wait_idle();
		write_reg(vps_pkg::REG_WIDTH, {48'hfffff_fffff_ff, 12'h001});
		write_reg(vps_pkg::REG_HEIGHT, 60'hfff);
		load_matrix(0, 1'b0);
		push_random(20);
		wait_idle();
		load_matrix(1, 1'b0);
		push_random(20);
		wait_idle();

		// sender holds mid-stream until everything sent so far has come out
		load_matrix(3, 1'b1);
		push_random(60);
		while (vertex_q.size() > 30) @(posedge clk);
		hold_send = 1'b1;
		while (projected_q.size() != 0 || in_valid) @(posedge clk);
		hold_send = 1'b0;
		wait_idle();

		send_idle_pct = 69; recv_idle_pct = 7;
		write_reg(vps_pkg::REG_WIDTH, 60'($urandom_range(0, 4095)));
		write_reg(vps_pkg::REG_HEIGHT, 60'($urandom_range(0, 4095)));
		load_matrix(3, 1'b1);
		push_random(150);
		wait_idle();

		send_idle_pct = 0; recv_idle_pct = 0;
		load_matrix(3, 1'b1);
		push_random(150);
		wait_idle();
		load_matrix(3, 1'b0);
		push_random(100);
		wait_idle();

		if (mismatches == 0 && projected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
